### src/cfqe_pkg.sv
// ----------------------------------------------------------------------------
// cfqe_pkg: shared types and constants for the CSV field quoting encoder
// Character codes, the field descriptor passed from front to back, the
// descriptor queue status and the output sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cfqe_pkg;

  // Default buffer capacity in characters; the supported range is 1 to 31.
  localparam int FIELD_MAX_DEF = 16;

  // The fill count covers the whole supported capacity range.
  localparam int CNT_W = 5;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // One closed field waiting to be encoded.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             nq;
    logic             ovf;
    logic             rend;
  } cfqe_desc_t;

  // Descriptor queue status. The bank bits select the buffer half.
  typedef struct packed {
    logic full;
    logic empty;
    logic wr_bank;
    logic rd_bank;
  } cfqe_qstat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OQUOTE,
    S_READ,
    S_EMIT,
    S_EMIT2,
    S_CQUOTE,
    S_CR,
    S_LF,
    S_COMMA
  } cfqe_state_t;

  function automatic logic is_special(input logic [7:0] c);
    return (c == CH_QUOTE) || (c == CH_COMMA) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

### src/cfqe_ram.sv
// ----------------------------------------------------------------------------
// cfqe_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/cfqe_front.sv
// ----------------------------------------------------------------------------
// cfqe_front: input side of the encoder
// Stores field characters into the current buffer half, tracks quoting and
// overflow, and queues a descriptor when a field closes.
// ----------------------------------------------------------------------------
`default_nettype none

module cfqe_front #(
  parameter int FIELD_MAX = cfqe_pkg::FIELD_MAX_DEF,
  parameter int ADDR_W    = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic [7:0]               in_data_byte,
  input  wire logic                     in_byte_present,
  input  wire logic                     in_field_end,
  input  wire logic                     in_record_end,
  input  wire cfqe_pkg::cfqe_qstat_t    qstat,
  output      logic                     ram_we,
  output      logic [ADDR_W-1:0]        ram_waddr,
  output      logic [7:0]               ram_wdata,
  output      logic                     push,
  output      cfqe_pkg::cfqe_desc_t     push_desc
);

  import cfqe_pkg::*;

  localparam int IDX_W = ADDR_W - 1;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             nq_r, nq_nxt;
  logic             ovf_r, ovf_nxt;
  logic             acc;
  logic             room;
  logic [CNT_W-1:0] cnt_upd;
  logic             nq_upd;
  logic             ovf_upd;

  // A full queue means both buffer halves are owned by the back end.
  assign in_stall = qstat.full;
  assign acc      = in_valid && !qstat.full;
  assign room     = cnt_r < CNT_W'(FIELD_MAX);

  assign ram_we    = acc && in_byte_present && room;
  assign ram_waddr = {qstat.wr_bank, cnt_r[IDX_W-1:0]};
  assign ram_wdata = in_data_byte;

  always_comb begin
    cnt_upd = cnt_r;
    nq_upd  = nq_r;
    ovf_upd = ovf_r;
    if (in_byte_present) begin
      if (room) begin
        cnt_upd = cnt_r + CNT_W'(1);
        nq_upd  = nq_r || is_special(in_data_byte);
      end else begin
        ovf_upd = 1'b1;
      end
    end
  end

  assign push           = acc && in_field_end;
  assign push_desc.cnt  = cnt_upd;
  assign push_desc.nq   = nq_upd;
  assign push_desc.ovf  = ovf_upd;
  assign push_desc.rend = in_record_end;

  always_comb begin
    cnt_nxt = cnt_r;
    nq_nxt  = nq_r;
    ovf_nxt = ovf_r;
    if (acc) begin
      if (in_field_end) begin
        cnt_nxt = '0;
        nq_nxt  = 1'b0;
        ovf_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_upd;
        nq_nxt  = nq_upd;
        ovf_nxt = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      nq_r  <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      nq_r  <= nq_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

### src/cfqe_queue.sv
// ----------------------------------------------------------------------------
// cfqe_queue: two-entry descriptor queue
// Each entry owns one half of the field buffer; the pointers double as the
// bank selects.
// ----------------------------------------------------------------------------
`default_nettype none

module cfqe_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire cfqe_pkg::cfqe_desc_t  push_desc,
  input  wire logic                  pop,
  output      cfqe_pkg::cfqe_desc_t  head,
  output      cfqe_pkg::cfqe_qstat_t qstat
);

  import cfqe_pkg::*;

  cfqe_desc_t entry_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head          = entry_r[rp_r];
  assign qstat.full    = cnt_r == 2'd2;
  assign qstat.empty   = cnt_r == 2'd0;
  assign qstat.wr_bank = wp_r;
  assign qstat.rd_bank = rp_r;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### src/cfqe_back.sv
// ----------------------------------------------------------------------------
// cfqe_back: output sequencer of the encoder
// Walks the head field of the queue and emits its encoded bytes through an
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfqe_back #(
  parameter int ADDR_W = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfqe_pkg::cfqe_desc_t  head,
  input  wire cfqe_pkg::cfqe_qstat_t qstat,
  output      logic                  pop,
  output      logic                  ram_re,
  output      logic [ADDR_W-1:0]     ram_raddr,
  input  wire logic [7:0]            ram_rdata,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [7:0]            out_byte,
  output      logic                  out_run_last,
  output      logic                  out_truncated
);

  import cfqe_pkg::*;

  localparam int IDX_W = ADDR_W - 1;

  cfqe_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r;
  logic             olast_r;
  logic             otrunc_r;

  logic             ld;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             idx_inc;
  logic             more;
  logic             dup;

  // The output register can take a byte when empty or being drained.
  assign ld   = !ovalid_r || !out_stall;
  assign more = idx_r < head.cnt;
  assign dup  = head.nq && (ram_rdata == CH_QUOTE);

  assign ram_raddr = {qstat.rd_bank, idx_r[IDX_W-1:0]};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = head.nq ? S_OQUOTE : S_READ;
        end
      end
      S_OQUOTE: begin
        if (ld) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (more) begin
          state_nxt = S_EMIT;
        end else if (head.nq) begin
          state_nxt = S_CQUOTE;
        end else begin
          state_nxt = head.rend ? S_CR : S_COMMA;
        end
      end
      S_EMIT: begin
        if (ld) begin
          state_nxt = dup ? S_EMIT2 : S_READ;
        end
      end
      S_EMIT2: begin
        if (ld) begin
          state_nxt = S_READ;
        end
      end
      S_CQUOTE: begin
        if (ld) begin
          state_nxt = head.rend ? S_CR : S_COMMA;
        end
      end
      S_CR: begin
        if (ld) begin
          state_nxt = S_LF;
        end
      end
      S_LF, S_COMMA: begin
        if (ld) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    emit      = 1'b0;
    emit_byte = CH_QUOTE;
    emit_last = 1'b0;
    idx_inc   = 1'b0;
    ram_re    = 1'b0;
    pop       = 1'b0;
    case (state_r)
      S_OQUOTE, S_CQUOTE: begin
        emit = ld;
      end
      S_READ: begin
        ram_re = more;
      end
      S_EMIT: begin
        emit      = ld;
        emit_byte = dup ? CH_QUOTE : ram_rdata;
        idx_inc   = ld && !dup;
      end
      S_EMIT2: begin
        emit      = ld;
        emit_byte = ram_rdata;
        idx_inc   = ld;
      end
      S_CR: begin
        emit      = ld;
        emit_byte = CH_CR;
      end
      S_LF: begin
        emit      = ld;
        emit_byte = CH_LF;
        emit_last = 1'b1;
        pop       = ld;
      end
      S_COMMA: begin
        emit      = ld;
        emit_byte = CH_COMMA;
        emit_last = 1'b1;
        pop       = ld;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = '0;
    end else if (idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    ovalid_nxt = emit ? 1'b1 : (ovalid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obyte_r  <= emit_byte;
      olast_r  <= emit_last;
      otrunc_r <= head.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid     = ovalid_r;
  assign out_byte      = obyte_r;
  assign out_run_last  = olast_r;
  assign out_truncated = otrunc_r;

endmodule

`default_nettype wire

### src/csv_field_quoting_encoder.sv
// ----------------------------------------------------------------------------
// csv_field_quoting_encoder: CSV field escaping encoder
// Buffers the characters of a field and emits it as escaped CSV text.
// ----------------------------------------------------------------------------
// Each input transfer carries at most one character of the current field; a
// transfer with field end set closes the field, and the block then emits the
// encoded field as a run of byte transfers: an opening quote, the characters
// with every double quote written twice, and a closing quote when the field
// holds a quote, comma, CR or LF, otherwise the characters unchanged, followed
// by a comma or by CR LF at the end of a record. The last byte of a run is
// marked, and every byte of a run carries the truncation flag when characters
// beyond FIELD_MAX were dropped. Input characters are taken one per cycle while
// in_stall is low. For each stored character the output sequencer first reads
// the buffer and then emits the byte, and a doubled quote is emitted as two
// bytes; a run begins with a start step, a read step finds the characters used
// up, and each framing byte has its own step; this read-then-emit step of the
// output sequencer sets the throughput. The field buffer has two halves, so one
// field can be collected while the previous one is being emitted; input is
// stalled only while both halves hold closed fields. There is no reset clearing
// pass: only characters written for a field are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_quoting_encoder #(
  parameter int FIELD_MAX = cfqe_pkg::FIELD_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_byte_present,
  input  wire logic       in_field_end,
  input  wire logic       in_record_end,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_byte,
  output      logic       out_run_last,
  output      logic       out_truncated
);

  import cfqe_pkg::*;

  // One buffer half per queue entry; the bank bit tops the address.
  localparam int IDX_W  = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 << IDX_W;

  cfqe_qstat_t       qstat;
  cfqe_desc_t        push_desc;
  cfqe_desc_t        head;
  logic              push;
  logic              pop;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // The front stores characters and queues a descriptor per closed field.
  cfqe_front #(
    .FIELD_MAX (FIELD_MAX),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_field_end    (in_field_end),
    .in_record_end   (in_record_end),
    .qstat           (qstat),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .push            (push),
    .push_desc       (push_desc)
  );

  cfqe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  cfqe_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The back end releases a buffer half when the run's last byte is loaded.
  cfqe_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_truncated (out_truncated)
  );

endmodule

`default_nettype wire
